>>> src/small_matrix_inverse_assert.svh
// assertion macros for the small matrix inverse block
// uses the module's own clock and reset ports; no other dependencies
`ifndef SMALL_MATRIX_INVERSE_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_ASSERT_SVH
`ifndef SYNTH
// checked only outside reset
`define SMI_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("small_matrix_inverse assertion failed");
// checked on every edge, reset included
`define SMI_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("small_matrix_inverse assertion failed");
`else
`define SMI_ASSERT(lbl, prop)
`define SMI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/smi_pkg.sv
// shared constants and tables of the small matrix inverse block
// no dependencies
`timescale 1ns / 1ps

package smi_pkg;

   localparam int ELEM_W_DEF = 16;   // default element width
   localparam int IN_FIELD_W = 16;   // width of each input field
   localparam int N_ELEM     = 9;
   localparam int N_PROD     = 18;
   localparam int INV_W      = 32;
   localparam int DET_W      = 49;

   localparam int REQ_TDATA_W = N_ELEM * IN_FIELD_W;
   localparam int RSP_TDATA_W = ((N_ELEM * INV_W + DET_W + 7) / 8) * 8;

   // quotient bits, numerator scale (2 * 2^24) and numerator bits fed in
   localparam int QBITS     = 34;
   localparam int NUM_SHIFT = 25;
   localparam int LOW_BITS  = QBITS - NUM_SHIFT;

   // determinant scaling to Q24.24
   localparam int SHIFT_1X1 = 16;
   localparam int SHIFT_2X2 = 8;

   // matrix size codes
   localparam logic [1:0] MSIZE_1 = 2'd1;
   localparam logic [1:0] MSIZE_2 = 2'd2;
   localparam logic [1:0] MSIZE_3 = 2'd3;
   localparam logic [1:0] MSIZE_RESET = MSIZE_3;

   localparam logic [INV_W-1:0] INV_MAX = 32'h7FFF_FFFF;
   localparam logic [INV_W-1:0] INV_MIN = 32'h8000_0000;

   localparam longint DET_MAX = (64'sd1 <<< (DET_W - 1)) - 64'sd1;
   localparam longint DET_MIN = -DET_MAX - 64'sd1;

   typedef logic [3:0] idx_type;

   // cofactor k is prod[2k] - prod[2k+1], prod[j] = a[PAIR_A[j]] * a[PAIR_B[j]]
   localparam idx_type PAIR_A [N_PROD] = '{
      4'd4, 4'd5,  4'd2, 4'd1,  4'd1, 4'd2,
      4'd5, 4'd3,  4'd0, 4'd2,  4'd2, 4'd0,
      4'd3, 4'd4,  4'd1, 4'd0,  4'd0, 4'd1};
   localparam idx_type PAIR_B [N_PROD] = '{
      4'd8, 4'd7,  4'd7, 4'd8,  4'd5, 4'd4,
      4'd6, 4'd8,  4'd8, 4'd6,  4'd3, 4'd5,
      4'd7, 4'd6,  4'd6, 4'd7,  4'd4, 4'd3};

endpackage

>>> src/small_matrix_inverse.sv
// small matrix inverse top level: 1x1, 2x2 or 3x3 inverse by adjugate over determinant
// depends on smi_pkg and small_matrix_inverse_assert.svh
`timescale 1ns / 1ps
`include "small_matrix_inverse_assert.svh"

// One row-major matrix of signed Q8.8 elements enters per req transaction and
// one result leaves per rsp transaction: the inverse in Q16.16 (rounded to
// nearest, ties away from zero, saturated), the determinant in Q24.24 and a
// singular flag that zeroes the inverse. The active corner size (1, 2 or 3;
// 0 acts as 1) is set through the csr port, by the user only while the block
// is idle; the block itself does not enforce this. A new matrix enters every
// cycle unless the rsp side stalls, which holds the whole pipeline in place.
// The restoring divider settles one quotient bit per stage over 34 stages.
module small_matrix_inverse
   import smi_pkg::*;
#(
   parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // inv00 .. inv22, determinant from the lowest bit up, zero padded
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // singular
   output logic [0:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_data
);

   localparam int W   = ELEMENT_WIDTH;
   localparam int PW  = 2 * W;          // element products
   localparam int AJW = 2 * W + 1;      // cofactors
   localparam int TW  = 3 * W + 1;      // element times cofactor
   localparam int DW  = 3 * W + 3;      // determinant and divider width
   localparam int XW  = ((DW + SHIFT_1X1) > DET_W ? DW + SHIFT_1X1 : DET_W) + 1;
   localparam int QB  = QBITS;

   // pipeline advance: the output register is free or being drained
   logic adv;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // size register
   logic [1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= MSIZE_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   // each element from the low ELEMENT_WIDTH bits of its field, zero extended beyond the field width
   logic [W-1:0] raw [N_ELEM];

   for (genvar e = 0; e < N_ELEM; e++) begin : g_raw
      if (W <= IN_FIELD_W) begin : g_narrow
         assign raw[e] = req_tdata[e*IN_FIELD_W +: W];
      end else begin : g_wide
         assign raw[e] = {{(W - IN_FIELD_W){1'b0}}, req_tdata[e*IN_FIELD_W +: IN_FIELD_W]};
      end
   end

   // stage 1: captured elements and normalized size
   logic signed [W-1:0] a1_ff [N_ELEM];
   logic [1:0]          n1_ff;
   logic [1:0]          n1_in;
   logic                v1_ff;

   always_comb begin
      n1_in = (size_ff == 2'd0) ? MSIZE_1 : size_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < N_ELEM; e++) begin
            a1_ff[e] <= signed'(raw[e]);
         end
         n1_ff <= n1_in;
      end
   end

   // stage 2: the eighteen element products
   logic signed [PW-1:0] p2_ff [N_PROD];
   logic signed [PW-1:0] p2_in [N_PROD];
   logic signed [W-1:0]  a2_ff [N_ELEM];
   logic [1:0]           n2_ff;
   logic                 v2_ff;

   always_comb begin
      for (int k = 0; k < N_PROD; k++) begin
         p2_in[k] = PW'(a1_ff[PAIR_A[k]]) * PW'(a1_ff[PAIR_B[k]]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff <= p2_in;
         a2_ff <= a1_ff;
         n2_ff <= n1_ff;
      end
   end

   // stage 3: cofactors of the 3x3 adjugate
   logic signed [AJW-1:0] adj3_ff [N_ELEM];
   logic signed [AJW-1:0] adj3_in [N_ELEM];
   logic signed [W-1:0]   a3_ff [N_ELEM];
   logic [1:0]            n3_ff;
   logic                  v3_ff;

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         adj3_in[k] = AJW'(p2_ff[2*k]) - AJW'(p2_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         adj3_ff <= adj3_in;
         a3_ff   <= a2_ff;
         n3_ff   <= n2_ff;
      end
   end

   // stage 4: first-row expansion terms
   logic signed [TW-1:0]  t4_ff [3];
   logic signed [TW-1:0]  t4_in [3];
   logic signed [AJW-1:0] adj4_ff [N_ELEM];
   logic signed [W-1:0]   a4_ff [N_ELEM];
   logic [1:0]            n4_ff;
   logic                  v4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         t4_in[c] = TW'(a3_ff[c]) * TW'(adj3_ff[3*c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t4_ff   <= t4_in;
         adj4_ff <= adj3_ff;
         a4_ff   <= a3_ff;
         n4_ff   <= n3_ff;
      end
   end

   // stage 5: determinant and lane cofactors for the active size
   logic signed [DW-1:0]  det5_ff;
   logic signed [DW-1:0]  det5_in;
   logic signed [AJW-1:0] ladj5_ff [N_ELEM];
   logic signed [AJW-1:0] ladj5_in [N_ELEM];
   logic [1:0]            n5_ff;
   logic                  v5_ff;

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         ladj5_in[k] = '0;
      end
      unique case (n4_ff)
         MSIZE_1: begin
            det5_in     = DW'(a4_ff[0]);
            ladj5_in[0] = AJW'(1);
         end
         MSIZE_2: begin
            det5_in     = DW'(adj4_ff[8]);
            ladj5_in[0] = AJW'(a4_ff[4]);
            ladj5_in[1] = -AJW'(a4_ff[1]);
            ladj5_in[3] = -AJW'(a4_ff[3]);
            ladj5_in[4] = AJW'(a4_ff[0]);
         end
         default: begin
            det5_in  = DW'(t4_ff[0]) + DW'(t4_ff[1]) + DW'(t4_ff[2]);
            ladj5_in = adj4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det5_ff  <= det5_in;
         ladj5_ff <= ladj5_in;
         n5_ff    <= n4_ff;
      end
   end

   // stage 6: magnitudes, quotient signs, singular flag, Q24.24 determinant
   logic [AJW-1:0]   am6_ff [N_ELEM];
   logic [AJW-1:0]   am6_in [N_ELEM];
   logic             neg6_ff [N_ELEM];
   logic             neg6_in [N_ELEM];
   logic [DW-1:0]    dm6_ff;
   logic [DW-1:0]    dm6_in;
   logic             sing6_ff;
   logic [DET_W-1:0] detq6_ff;
   logic [DET_W-1:0] detq6_in;
   logic             v6_ff;

   always_comb begin
      logic signed [XW-1:0] dx;
      dx = XW'(det5_ff);
      unique case (n5_ff)
         MSIZE_1: dx = dx <<< SHIFT_1X1;
         MSIZE_2: dx = dx <<< SHIFT_2X2;
         default: dx = dx;
      endcase
      if (dx > XW'(DET_MAX)) begin
         detq6_in = DET_W'(DET_MAX);
      end else if (dx < XW'(DET_MIN)) begin
         detq6_in = DET_W'(DET_MIN);
      end else begin
         detq6_in = dx[DET_W-1:0];
      end
      dm6_in = det5_ff[DW-1] ? DW'(-det5_ff) : DW'(det5_ff);
      for (int k = 0; k < N_ELEM; k++) begin
         am6_in[k]  = ladj5_ff[k][AJW-1] ? AJW'(-ladj5_ff[k]) : AJW'(ladj5_ff[k]);
         neg6_in[k] = ladj5_ff[k][AJW-1] ^ det5_ff[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         am6_ff   <= am6_in;
         neg6_ff  <= neg6_in;
         dm6_ff   <= dm6_in;
         sing6_ff <= (det5_ff == '0);
         detq6_ff <= detq6_in;
      end
   end

   // divider: step 0 loads the top numerator bits and checks for overflow,
   // steps 1..QB each settle one bit of floor(2 * |adj| * 2^24 / |det|)
   logic [DW-1:0]    rem_ff  [QB+1][N_ELEM];
   logic [QB-1:0]    nl_ff   [QB+1][N_ELEM];
   logic [QB-1:0]    q_ff    [QB+1][N_ELEM];
   logic             ovf_ff  [QB+1][N_ELEM];
   logic             neg_ff  [QB+1][N_ELEM];
   logic [DW-1:0]    dm_ff   [QB+1];
   logic             sing_ff [QB+1];
   logic [DET_W-1:0] detq_ff [QB+1];
   logic             vq_ff   [QB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N_ELEM; k++) begin
            rem_ff[0][k] <= DW'(am6_ff[k] >> LOW_BITS);
            ovf_ff[0][k] <= DW'(am6_ff[k] >> LOW_BITS) >= dm6_ff;
            nl_ff[0][k]  <= {am6_ff[k][LOW_BITS-1:0], {NUM_SHIFT{1'b0}}};
            q_ff[0][k]   <= '0;
            neg_ff[0][k] <= neg6_ff[k];
         end
         dm_ff[0]   <= dm6_ff;
         sing_ff[0] <= sing6_ff;
         detq_ff[0] <= detq6_ff;
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_div
      logic [DW-1:0] rem_in [N_ELEM];
      logic          qbit_in [N_ELEM];

      always_comb begin
         logic [DW:0] rr;
         for (int k = 0; k < N_ELEM; k++) begin
            rr = {rem_ff[s-1][k], nl_ff[s-1][k][QB-1]};
            qbit_in[k] = rr >= {1'b0, dm_ff[s-1]};
            rem_in[k]  = qbit_in[k] ? DW'(rr - {1'b0, dm_ff[s-1]}) : DW'(rr);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < N_ELEM; k++) begin
               rem_ff[s][k] <= rem_in[k];
               nl_ff[s][k]  <= {nl_ff[s-1][k][QB-2:0], 1'b0};
               q_ff[s][k]   <= {q_ff[s-1][k][QB-2:0], qbit_in[k]};
               ovf_ff[s][k] <= ovf_ff[s-1][k];
               neg_ff[s][k] <= neg_ff[s-1][k];
            end
            dm_ff[s]   <= dm_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
            detq_ff[s] <= detq_ff[s-1];
         end
      end
   end

   // output stage: zero a singular result, else round half away from zero, saturate, apply sign
   logic [INV_W-1:0] rsp_inv_ff [N_ELEM];
   logic [INV_W-1:0] rsp_inv_in [N_ELEM];
   logic [DET_W-1:0] rsp_det_ff;
   logic             rsp_sing_ff;

   always_comb begin
      logic [QB:0]   qs;
      logic [QB-1:0] qh;
      for (int k = 0; k < N_ELEM; k++) begin
         qs = {1'b0, q_ff[QB][k]} + (QB+1)'(1);
         qh = qs[QB:1];
         if (sing_ff[QB]) begin
            rsp_inv_in[k] = '0;
         end else if (neg_ff[QB][k]) begin
            if (ovf_ff[QB][k] || qh > QB'(INV_MIN)) begin
               rsp_inv_in[k] = INV_MIN;
            end else begin
               rsp_inv_in[k] = INV_W'(QB'(0) - qh);
            end
         end else begin
            if (ovf_ff[QB][k] || qh > QB'(INV_MAX)) begin
               rsp_inv_in[k] = INV_MAX;
            end else begin
               rsp_inv_in[k] = qh[INV_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_inv_ff  <= rsp_inv_in;
         rsp_det_ff  <= sing_ff[QB] ? '0 : detq_ff[QB];
         rsp_sing_ff <= sing_ff[QB];
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= QB; s++) begin
            vq_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vq_ff[0] <= v6_ff;
         for (int s = 1; s <= QB; s++) begin
            vq_ff[s] <= vq_ff[s-1];
         end
         rsp_valid_ff <= vq_ff[QB];
      end
   end

   // result transaction packing
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < N_ELEM; k++) begin
         rsp_tdata[k*INV_W +: INV_W] = rsp_inv_ff[k];
      end
      rsp_tdata[N_ELEM*INV_W +: DET_W] = rsp_det_ff;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_sing_ff;

   // a singular result carries no inverse and no determinant
   `SMI_ASSERT(a_sing_zero, rsp_valid_ff && rsp_sing_ff |-> rsp_det_ff == '0 && rsp_tdata[N_ELEM*INV_W-1:0] == '0)
   // saturation never turns a nonzero determinant into zero
   `SMI_ASSERT(a_det_nonzero, rsp_valid_ff && !rsp_sing_ff |-> rsp_det_ff != '0)
   // reset empties the output register
   `SMI_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff)

endmodule
